// ===== hdl/md5fl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5fl_pkg: shared types, constants and functions
// Item types, lane control struct, MD5 step constants and byte helpers.
// ----------------------------------------------------------------------------
package md5fl_pkg;

  // Number of hashing lanes; digests go out for at most four of them.
  localparam int LANE_COUNT = 4;
  localparam int EMIT_COUNT = (LANE_COUNT < 4) ? LANE_COUNT : 4;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  typedef struct packed {
    logic [7:0] lane0_byte;
    logic [7:0] lane1_byte;
    logic [7:0] lane2_byte;
    logic [7:0] lane3_byte;
    logic       byte_valid;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  lane_index;
    logic [63:0] digest_front;
    logic [63:0] digest_back;
    logic        final_digest;
  } out_item_t;

  // Control that the sequencer sends to every lane.
  typedef struct packed {
    logic       push;
    logic [5:0] fill;
    logic       round_en;
    logic [5:0] round;
    logic       chain_init;
  } lane_ctl_t;

  // Additive constant of each step.
  function automatic logic [31:0] round_add(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Left rotate amount of each step.
  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by each step.
  function automatic logic [3:0] word_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'((lo << 2) + lo + 4'd1);
      2'd2:    g = 4'((lo << 1) + lo + 4'd5);
      default: g = 4'((lo << 3) - lo);
    endcase
    return g;
  endfunction

  // Two chaining words as eight bytes, lowest byte first.
  function automatic logic [63:0] swap_pair(input logic [31:0] hi, input logic [31:0] lo);
    return {hi[7:0], hi[15:8], hi[23:16], hi[31:24],
            lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
  endfunction

endpackage

// ===== hdl/md5fl_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5fl_lane: one MD5 hashing lane
// Holds a 64-byte block and the chaining words; runs one step per cycle while round_en is high.
// ----------------------------------------------------------------------------
module md5fl_lane
  import md5fl_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  lane_ctl_t       ctl,
  input  logic [7:0]      lane_byte,
  output logic [3:0][31:0] chain
);

  logic [15:0][31:0] blk_r;
  logic [3:0][31:0]  chain_r, chain_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_in, b_in, c_in, d_in;
  logic [31:0] f, t, b_new;
  logic [63:0] rot_w;

  // Block buffer: one byte written per push, little-endian within a word.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      blk_r[ctl.fill[5:2]][{ctl.fill[1:0], 3'b000} +: 8] <= lane_byte;
    end
  end

  // The first step starts from the chaining words.
  always_comb begin
    if (ctl.round == '0) begin
      a_in = chain_r[0]; b_in = chain_r[1]; c_in = chain_r[2]; d_in = chain_r[3];
    end else begin
      a_in = a_r; b_in = b_r; c_in = c_r; d_in = d_r;
    end
    case (ctl.round[5:4])
      2'd0:    f = (b_in & c_in) | (~b_in & d_in);
      2'd1:    f = (b_in & d_in) | (c_in & ~d_in);
      2'd2:    f = b_in ^ c_in ^ d_in;
      default: f = c_in ^ (b_in | ~d_in);
    endcase
    t = a_in + f + blk_r[word_index(ctl.round)] + round_add(ctl.round);
    rot_w = {t, t} << rot_amount(ctl.round);
    b_new = b_in + rot_w[63:32];
  end

  // Step registers.
  always_ff @(posedge clk) begin
    if (ctl.round_en) begin
      a_r <= d_in;
      b_r <= b_new;
      c_r <= b_in;
      d_r <= c_in;
    end
  end

  // Chaining words load the MD5 initial values on reset or chain_init and fold in the result on the last step.
  always_comb begin
    chain_nxt = chain_r;
    if (!rst_n || ctl.chain_init) begin
      chain_nxt = {INIT_D, INIT_C, INIT_B, INIT_A};
    end else if (ctl.round_en && ctl.round == LAST_ROUND) begin
      chain_nxt[0] = chain_r[0] + d_in;
      chain_nxt[1] = chain_r[1] + b_new;
      chain_nxt[2] = chain_r[2] + b_in;
      chain_nxt[3] = chain_r[3] + c_in;
    end
  end

  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
  end

  assign chain = chain_r;

endmodule

// ===== hdl/md5_hash_four_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_hash_four_lane: four MD5 digests computed side by side
// Sequencer, byte padding and digest merge around four hashing lanes.
// ----------------------------------------------------------------------------
// Usage: each input item carries one byte per lane plus byte_valid and
// message_end. Each valid byte is stored in its lane's block buffer. When
// a 64-byte block fills, in_stall rises while every lane runs one MD5 step
// per cycle on its own step logic. On message_end the block inserts the pad
// bytes one per cycle (0x80, zeros, eight length bytes), hashing each block
// that fills. The four digests then go out in lane order, one per cycle
// while out_stall is low; final_digest marks the lane 3 digest. Input is
// stalled from message_end until the last digest is taken. A stalled digest
// holds its value. Reset (synchronous, active low) sets the chaining words
// to the MD5 initial values and clears length and fill position; block
// buffer contents need no reset.
// ----------------------------------------------------------------------------
module md5_hash_four_lane
  import md5fl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [63:0] len_r, len_nxt;
  logic        pad_r, pad_nxt;
  logic        first_r, first_nxt;
  logic        lenph_r, lenph_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  oidx_r, oidx_nxt;

  logic        in_acc, push_in, push_pad, push, len_byte;
  logic [7:0]  pad_byte;
  logic [7:0]  in_bytes [4];
  lane_ctl_t   ctl;
  logic        chain_init;
  logic [LANE_COUNT-1:0][3:0][31:0] chains;
  logic [3:0][31:0] sel_chain;

  assign in_stall = (state_r != S_IN);
  assign in_acc   = in_valid && !in_stall;
  assign push_in  = in_acc && in_data.byte_valid;
  assign push_pad = (state_r == S_PAD);
  assign push     = push_in || push_pad;

  // Pad byte: the mark first, then zeros, then the length from position 56.
  assign len_byte = !first_r && (lenph_r || fill_r == LEN_START);
  always_comb begin
    if (first_r) begin
      pad_byte = PAD_MARK;
    end else if (len_byte) begin
      pad_byte = len_r[{fill_r[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  assign in_bytes[0] = in_data.lane0_byte;
  assign in_bytes[1] = in_data.lane1_byte;
  assign in_bytes[2] = in_data.lane2_byte;
  assign in_bytes[3] = in_data.lane3_byte;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = push ? 6'(fill_r + 6'd1) : fill_r;
    round_nxt  = round_r;
    bitlen_nxt = push_in ? 64'(bitlen_r + 64'd8) : bitlen_r;
    len_nxt    = len_r;
    pad_nxt    = pad_r;
    first_nxt  = first_r;
    lenph_nxt  = lenph_r;
    done_nxt   = done_r;
    oidx_nxt   = oidx_r;
    chain_init = 1'b0;
    case (state_r)
      S_IN: begin
        if (in_acc && in_data.message_end) begin
          len_nxt   = bitlen_nxt;
          pad_nxt   = 1'b1;
          first_nxt = 1'b1;
        end
        if (push_in && fill_r == LAST_POS) begin
          state_nxt = S_HASH;
        end else if (in_acc && in_data.message_end) begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        first_nxt = 1'b0;
        if (len_byte) begin
          lenph_nxt = 1'b1;
          if (fill_r == LAST_POS) begin
            done_nxt = 1'b1;
          end
        end
        if (fill_r == LAST_POS) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        round_nxt = 6'(round_r + 6'd1);
        if (round_r == LAST_ROUND) begin
          if (done_r) begin
            state_nxt = S_OUT;
          end else if (pad_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IN;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (oidx_r == 2'(EMIT_COUNT - 1)) begin
            chain_init = 1'b1;
            state_nxt  = S_IN;
            fill_nxt   = '0;
            bitlen_nxt = '0;
            pad_nxt    = 1'b0;
            lenph_nxt  = 1'b0;
            done_nxt   = 1'b0;
            oidx_nxt   = '0;
          end else begin
            oidx_nxt = 2'(oidx_r + 2'd1);
          end
        end
      end
      default: state_nxt = S_IN;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IN;
      fill_r   <= '0;
      round_r  <= '0;
      bitlen_r <= '0;
      pad_r    <= 1'b0;
      first_r  <= 1'b0;
      lenph_r  <= 1'b0;
      done_r   <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      round_r  <= round_nxt;
      bitlen_r <= bitlen_nxt;
      pad_r    <= pad_nxt;
      first_r  <= first_nxt;
      lenph_r  <= lenph_nxt;
      done_r   <= done_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  assign ctl.push       = push;
  assign ctl.fill       = fill_r;
  assign ctl.round_en   = (state_r == S_HASH);
  assign ctl.round      = round_r;
  assign ctl.chain_init = chain_init;

  // Hashing lanes; a lane past the fourth takes the byte of lane index mod 4.
  for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
    md5fl_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .lane_byte (push_pad ? pad_byte : in_bytes[l % 4]),
      .chain     (chains[l])
    );
  end

  // Merge: pick the digest of the lane being emitted.
  always_comb begin
    sel_chain = chains[0];
    for (int e = 0; e < EMIT_COUNT; e++) begin
      if (oidx_r == 2'(e)) begin
        sel_chain = chains[e];
      end
    end
  end

  assign out_valid             = (state_r == S_OUT);
  assign out_data.lane_index   = oidx_r;
  assign out_data.digest_front = swap_pair(sel_chain[0], sel_chain[1]);
  assign out_data.digest_back  = swap_pair(sel_chain[2], sel_chain[3]);
  assign out_data.final_digest = (oidx_r == 2'(EMIT_COUNT - 1));

endmodule

// ===== hdl/md5fl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5fl_checker: port-level checks for the four-lane MD5 block
// Watches the item channels and the digest sequence.
// ----------------------------------------------------------------------------
module md5fl_checker
  import md5fl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled digest holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled digest changed");

  // No item is taken while digests are going out.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during digest output");

  // Digests follow in lane order.
  a_lane_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.final_digest |=>
      out_valid && out_data.lane_index == 2'($past(out_data.lane_index) + 2'd1))
    else $error("digest lane order broken");

  // The run ends after the final digest.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.final_digest |=> !out_valid)
    else $error("digest after final digest");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("digest valid after reset");

endmodule

bind md5_hash_four_lane md5fl_checker u_md5fl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
